// ===== rtl/core/crc_checked_frame_receiver_defines.svh =====
// Assertion macros used by the frame receiver sequencer.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define CCFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define CCFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ccfr_pkg.sv =====
// Shared constants and types for the CRC-checked frame receiver.
// No dependencies; every other RTL file but the assertion macro header uses it.
`default_nettype none

package ccfr_pkg;

   localparam int PAYLOAD_BYTES = 32;
   localparam int PAY_ADDR_W    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
   localparam int LEN_W         = 6;
   localparam int BYTE_W        = 8;
   localparam int CRC_W         = 16;
   localparam int CSR_IDX_W     = 1;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PREAMBLE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_PREAMBLE = 1'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] first_preamble;
      logic [BYTE_W-1:0] second_preamble;
   } ccfr_cfg_type;

   typedef struct packed {
      logic              start;
      logic              restart;
      logic [BYTE_W-1:0] data;
   } ccfr_crc_ctrl_type;

   typedef struct packed {
      logic             busy;
      logic [CRC_W-1:0] crc;
   } ccfr_crc_sts_type;

   typedef struct packed {
      logic                  wr_en;
      logic [PAY_ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0]     wr_data;
      logic                  rd_en;
      logic [PAY_ADDR_W-1:0] rd_addr;
   } ccfr_ram_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/ccfr_req_if.sv =====
// Request channel: one received serial byte per request.
// Depends on ccfr_pkg for the byte width.
`default_nettype none

interface ccfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [ccfr_pkg::BYTE_W-1:0]  byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ccfr_rsp_if.sv =====
// Result channel: one payload byte of an accepted frame per request.
// Depends on ccfr_pkg for the field widths.
`default_nettype none

interface ccfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ccfr_pkg::BYTE_W-1:0]  command;
   logic [ccfr_pkg::LEN_W-1:0]   length;
   logic [ccfr_pkg::BYTE_W-1:0]  data_byte;
   logic                         has_data;
   logic                         is_last;

   modport source (output valid, output command, output length, output data_byte,
                   output has_data, output is_last, input ready);
   modport sink   (input valid, input command, input length, input data_byte,
                   input has_data, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ccfr_crc_unit.sv =====
// Bit-serial CRC-16 (poly 0x8005, MSB first): one bit per cycle.
// Depends on ccfr_pkg.
`default_nettype none

module ccfr_crc_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ccfr_pkg::ccfr_crc_ctrl_type ctrl,
   output      ccfr_pkg::ccfr_crc_sts_type  sts
);
   import ccfr_pkg::*;

   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic [2:0]        bit_ff, bit_in;
   logic              busy_ff, busy_in;
   logic              top;

   assign top = crc_ff[CRC_W-1] ^ data_ff[BYTE_W-1];

   always_comb begin
      crc_in  = crc_ff;
      data_in = data_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         crc_in  = {crc_ff[CRC_W-2:0], 1'b0} ^ (top ? CRC_POLY : '0);
         data_in = {data_ff[BYTE_W-2:0], 1'b0};
         bit_in  = bit_ff + 3'd1;
         if (bit_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end else if (ctrl.start) begin
         // seed afresh at the length byte
         if (ctrl.restart) begin
            crc_in = CRC_INIT;
         end
         data_in = ctrl.data;
         bit_in  = 3'd0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         bit_ff  <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         bit_ff  <= bit_in;
         busy_ff <= busy_in;
      end
      data_ff <= data_in;
   end

   assign sts.busy = busy_ff;
   assign sts.crc  = crc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ccfr_payload_ram.sv =====
// Payload store: one write and one registered read port.
// Depends on ccfr_pkg.
`default_nettype none

module ccfr_payload_ram (
   input  wire logic                        clock,
   input  wire ccfr_pkg::ccfr_ram_ctrl_type ctrl,
   output      logic [ccfr_pkg::BYTE_W-1:0] rd_data
);
   import ccfr_pkg::*;

   logic [BYTE_W-1:0] mem_ff [PAYLOAD_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ccfr_sequencer.sv =====
// Frame sequencer: preamble hunt, header and payload capture, CRC check, emission.
// Depends on ccfr_pkg, ccfr_req_if, ccfr_rsp_if and the assertion macro header.
`default_nettype none
`include "crc_checked_frame_receiver_defines.svh"

module ccfr_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ccfr_pkg::ccfr_cfg_type      cfg,
   ccfr_req_if.sink                         req_chan,
   ccfr_rsp_if.source                       rsp_chan,
   output      ccfr_pkg::ccfr_crc_ctrl_type crc_ctrl,
   input  wire ccfr_pkg::ccfr_crc_sts_type  crc_sts,
   output      ccfr_pkg::ccfr_ram_ctrl_type ram_ctrl,
   input  wire logic [ccfr_pkg::BYTE_W-1:0] ram_rd_data
);
   import ccfr_pkg::*;

   typedef enum logic [3:0] {
      PH_SEEK1,
      PH_SEEK2,
      PH_LEN,
      PH_CMD,
      PH_PAY,
      PH_CRCLO,
      PH_CRCHI,
      PH_RD,
      PH_SHOW
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  index_ff, index_in;
   logic [CNT_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0] command_ff, command_in;
   logic [BYTE_W-1:0] crc_low_ff, crc_low_in;

   logic              accept;
   logic [BYTE_W-1:0] rx_byte;
   logic [BYTE_W-1:0] clamped;
   logic [CNT_W-1:0]  index_next;
   logic              has_data;
   logic              is_last;

   assign rx_byte    = req_chan.byte_in;
   assign accept     = req_chan.valid && req_chan.ready;
   assign clamped    = (rx_byte <= BYTE_W'(PAYLOAD_BYTES)) ? rx_byte : BYTE_W'(PAYLOAD_BYTES);
   assign index_next = CNT_W'(index_ff + 1'b1);
   assign has_data   = (length_ff != '0);
   assign is_last    = !has_data || (index_next == length_ff);

   // hold off requests while the CRC unit shifts or a frame is being emitted
   assign req_chan.ready = !crc_sts.busy &&
      (phase_ff inside {PH_SEEK1, PH_SEEK2, PH_LEN, PH_CMD, PH_PAY, PH_CRCLO, PH_CRCHI});

   always_comb begin
      phase_in   = phase_ff;
      index_in   = index_ff;
      length_in  = length_ff;
      command_in = command_ff;
      crc_low_in = crc_low_ff;

      crc_ctrl.start   = 1'b0;
      crc_ctrl.restart = 1'b0;
      crc_ctrl.data    = rx_byte;

      ram_ctrl.wr_en   = 1'b0;
      ram_ctrl.wr_addr = index_ff[PAY_ADDR_W-1:0];
      ram_ctrl.wr_data = rx_byte;
      ram_ctrl.rd_en   = (phase_ff == PH_RD);
      ram_ctrl.rd_addr = index_ff[PAY_ADDR_W-1:0];

      case (phase_ff)
         PH_SEEK1: begin
            if (accept) begin
               index_in = '0;
               phase_in = (rx_byte == cfg.first_preamble) ? PH_SEEK2 : PH_SEEK1;
            end
         end
         PH_SEEK2: begin
            if (accept) begin
               phase_in = (rx_byte == cfg.second_preamble) ? PH_LEN : PH_SEEK1;
            end
         end
         PH_LEN: begin
            if (accept) begin
               length_in        = CNT_W'(clamped);
               crc_ctrl.start   = 1'b1;
               crc_ctrl.restart = 1'b1;
               crc_ctrl.data    = clamped;
               phase_in         = PH_CMD;
            end
         end
         PH_CMD: begin
            if (accept) begin
               command_in     = rx_byte;
               crc_ctrl.start = 1'b1;
               index_in       = '0;
               phase_in       = (length_ff == '0) ? PH_CRCLO : PH_PAY;
            end
         end
         PH_PAY: begin
            if (accept) begin
               ram_ctrl.wr_en = (index_ff < CNT_W'(PAYLOAD_BYTES));
               crc_ctrl.start = 1'b1;
               index_in       = index_next;
               if (index_next >= length_ff) begin
                  phase_in = PH_CRCLO;
               end
            end
         end
         PH_CRCLO: begin
            if (accept) begin
               crc_low_in = rx_byte;
               phase_in   = PH_CRCHI;
            end
         end
         PH_CRCHI: begin
            if (accept) begin
               index_in = '0;
               if ({rx_byte, crc_low_ff} == crc_sts.crc) begin
                  phase_in = (length_ff == '0) ? PH_SHOW : PH_RD;
               end else begin
                  // drop the frame
                  phase_in = PH_SEEK1;
               end
            end
         end
         PH_RD: begin
            phase_in = PH_SHOW;
         end
         PH_SHOW: begin
            if (rsp_chan.ready) begin
               if (is_last) begin
                  index_in = '0;
                  phase_in = PH_SEEK1;
               end else begin
                  index_in = index_next;
                  phase_in = PH_RD;
               end
            end
         end
         default: begin
            phase_in = PH_SEEK1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEEK1;
         index_ff   <= '0;
         length_ff  <= '0;
         command_ff <= '0;
         crc_low_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         length_ff  <= length_in;
         command_ff <= command_in;
         crc_low_ff <= crc_low_in;
      end
   end

   assign rsp_chan.valid     = (phase_ff == PH_SHOW);
   assign rsp_chan.command   = command_ff;
   assign rsp_chan.length    = LEN_W'(length_ff);
   assign rsp_chan.data_byte = has_data ? ram_rd_data : '0;
   assign rsp_chan.has_data  = has_data;
   assign rsp_chan.is_last   = is_last;

   `CCFR_ASSERT_NEXT(a_len_starts_crc, accept && (phase_ff == PH_LEN), crc_sts.busy, "CRC unit idle after length byte")
   `CCFR_ASSERT_NOW(a_no_req_while_rsp, rsp_chan.valid, !req_chan.ready, "request taken during emission")
   `CCFR_ASSERT_NEXT(a_last_ends_frame, rsp_chan.valid && rsp_chan.ready && rsp_chan.is_last, (phase_ff == PH_SEEK1) && !rsp_chan.valid, "frame emission did not end on last")
   `CCFR_ASSERT_NOW(a_store_in_range, ram_ctrl.wr_en, index_ff < length_ff, "payload write beyond frame length")

endmodule

`default_nettype wire

// ===== rtl/core/crc_checked_frame_receiver.sv =====
// Top level of the CRC-checked frame receiver: preamble registers and wiring.
// Depends on ccfr_pkg, the channel interfaces, ccfr_crc_unit, ccfr_payload_ram, ccfr_sequencer.
//
//   Channel   Direction  Carries
//   req_chan  in         byte_in, one serial byte per request
//   rsp_chan  out        command, length, data_byte, has_data, is_last
//   csr_*     in         write of first_preamble (index 0) or second_preamble (index 1)
//
// Preamble and CRC bytes are taken at one per cycle while the CRC unit is idle;
// length, command and payload bytes each hold off the next request while it shifts.
// A good frame then emits each result after a payload RAM read (none if it is empty),
// held while rsp_chan.ready is low; no request is taken during emission.
// Reset is synchronous and active high; the payload RAM needs no clearing pass.
`default_nettype none

module crc_checked_frame_receiver (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [ccfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ccfr_pkg::BYTE_W-1:0]    csr_wdata,
   ccfr_req_if.sink                            req_chan,
   ccfr_rsp_if.source                          rsp_chan
);
   import ccfr_pkg::*;

   logic [BYTE_W-1:0] first_preamble_ff;
   logic [BYTE_W-1:0] second_preamble_ff;

   ccfr_cfg_type      cfg;
   ccfr_crc_ctrl_type crc_ctrl;
   ccfr_crc_sts_type  crc_sts;
   ccfr_ram_ctrl_type ram_ctrl;
   logic [BYTE_W-1:0] ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_preamble_ff  <= '0;
         second_preamble_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_PREAMBLE:  first_preamble_ff  <= csr_wdata;
            CSR_SECOND_PREAMBLE: second_preamble_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.first_preamble  = first_preamble_ff;
   assign cfg.second_preamble = second_preamble_ff;

   ccfr_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .sts   (crc_sts)
   );

   ccfr_payload_ram u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .rd_data (ram_rd_data)
   );

   ccfr_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .crc_ctrl    (crc_ctrl),
      .crc_sts     (crc_sts),
      .ram_ctrl    (ram_ctrl),
      .ram_rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for crc_checked_frame_receiver: feeds framed serial bytes,
// predicts the emitted payload results and checks them field by field.
// Depends on ccfr_pkg, ccfr_req_if, ccfr_rsp_if and the receiver RTL.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccfr_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 400;

   typedef enum logic [2:0] {
      SEEK_FIRST, SEEK_SECOND, TAKE_LENGTH, TAKE_COMMAND,
      TAKE_PAYLOAD, TAKE_CRC_LOW, TAKE_CRC_HIGH
   } frame_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data_byte;
      logic              has_data;
      logic              is_last;
   } frame_result_type;

   class frame_scoreboard_type;
      frame_state_type   state;
      logic [LEN_W-1:0]  pay_idx;
      logic [LEN_W-1:0]  frame_len;
      logic [BYTE_W-1:0] frame_cmd;
      logic [BYTE_W-1:0] crc_low;
      logic [CRC_W-1:0]  frame_crc;
      logic [BYTE_W-1:0] store [PAYLOAD_BYTES];
      logic [BYTE_W-1:0] first_pre;
      logic [BYTE_W-1:0] second_pre;
      frame_result_type  pending [$];
      int                failures;

      function new();
         state      = SEEK_FIRST;
         pay_idx    = '0;
         frame_len  = '0;
         frame_cmd  = '0;
         crc_low    = '0;
         frame_crc  = CRC_INIT;
         first_pre  = '0;
         second_pre = '0;
         failures   = 0;
      endfunction

      // CRC-16, MSB first, one byte at a time
      static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc,
                                                 logic [BYTE_W-1:0] b);
         logic fb;
         for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb  = crc[CRC_W-1] ^ b[i];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb) crc = crc ^ CRC_POLY;
         end
         return crc;
      endfunction

      function void set_preamble(logic [CSR_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
         if (idx == CSR_FIRST_PREAMBLE) first_pre = v;
         else if (idx == CSR_SECOND_PREAMBLE) second_pre = v;
      endfunction

      function void note_request(logic [BYTE_W-1:0] b);
         frame_result_type r;
         logic [CRC_W-1:0] got;
         case (state)
            SEEK_SECOND: begin
               // a mismatch is not retried as a first preamble
               state = (b == second_pre) ? TAKE_LENGTH : SEEK_FIRST;
            end
            TAKE_LENGTH: begin
               frame_len = (b <= PAYLOAD_BYTES) ? b[LEN_W-1:0] : LEN_W'(PAYLOAD_BYTES);
               frame_crc = crc_step(CRC_INIT, BYTE_W'(frame_len));
               state     = TAKE_COMMAND;
            end
            TAKE_COMMAND: begin
               frame_cmd = b;
               frame_crc = crc_step(frame_crc, b);
               pay_idx   = '0;
               state     = (frame_len == 0) ? TAKE_CRC_LOW : TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD: begin
               store[pay_idx[PAY_ADDR_W-1:0]] = b;
               frame_crc      = crc_step(frame_crc, b);
               pay_idx        = pay_idx + 1'b1;
               if (pay_idx >= frame_len) state = TAKE_CRC_LOW;
            end
            TAKE_CRC_LOW: begin
               crc_low = b;
               state   = TAKE_CRC_HIGH;
            end
            TAKE_CRC_HIGH: begin
               got     = {b, crc_low};
               state   = SEEK_FIRST;
               pay_idx = '0;
               if (got == frame_crc) begin
                  r.command = frame_cmd;
                  r.length  = frame_len;
                  if (frame_len == 0) begin
                     r.data_byte = '0;
                     r.has_data  = 1'b0;
                     r.is_last   = 1'b1;
                     pending.push_back(r);
                  end else begin
                     for (int k = 0; k < frame_len; k++) begin
                        r.data_byte = store[PAY_ADDR_W'(k)];
                        r.has_data  = 1'b1;
                        r.is_last   = (k == frame_len - 1);
                        pending.push_back(r);
                     end
                  end
               end
            end
            default: begin
               pay_idx = '0;
               state   = (b == first_pre) ? SEEK_SECOND : SEEK_FIRST;
            end
         endcase
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         bit bad;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: cmd %h len %0d data %h has_data %b last %b",
                        got.command, got.length, got.data_byte, got.has_data,
                        got.is_last);
            return;
         end
         want = pending.pop_front();
         bad  = (got.command !== want.command) || (got.length !== want.length) ||
                (got.data_byte !== want.data_byte) || (got.has_data !== want.has_data) ||
                (got.is_last !== want.is_last);
         if (bad) begin
            failures++;
            if (failures <= 10)
               $display({"result mismatch: expected cmd %h len %0d data %h has %b last %b,",
                         " got cmd %h len %0d data %h has %b last %b"},
                        want.command, want.length, want.data_byte, want.has_data,
                        want.is_last, got.command, got.length, got.data_byte,
                        got.has_data, got.is_last);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [BYTE_W-1:0]     csr_wdata;

   ccfr_req_if req_chan ();
   ccfr_rsp_if rsp_chan ();

   crc_checked_frame_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   frame_scoreboard_type sb = new();

   logic [BYTE_W-1:0] cur_first;
   logic [BYTE_W-1:0] cur_second;
   int                requests_sent = 0;
   int                cycle_count   = 0;
   bit                no_idle       = 1'b0;
   bit                hold_request  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   // result side: check handshakes, stall at random, hold off once for a long stretch
   initial begin
      int hold_left;
      frame_result_type got;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.command   = rsp_chan.command;
            got.length    = rsp_chan.length;
            got.data_byte = rsp_chan.data_byte;
            got.has_data  = rsp_chan.has_data;
            got.is_last   = rsp_chan.is_last;
            sb.check_result(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(99) >= 6);
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (!no_idle && $urandom_range(99) < 6) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.byte_in <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(b);
      requests_sent++;
   endtask

   // fill < 0 gives random payload bytes, otherwise every byte is fill
   task automatic send_frame(input logic [BYTE_W-1:0] len_byte,
                             input logic [BYTE_W-1:0] cmd,
                             input int fill, input bit corrupt);
      logic [CRC_W-1:0]  crc;
      logic [BYTE_W-1:0] b;
      int                n;
      n = (len_byte <= PAYLOAD_BYTES) ? len_byte : PAYLOAD_BYTES;
      send_byte(cur_first);
      send_byte(cur_second);
      send_byte(len_byte);
      crc = frame_scoreboard_type::crc_step(CRC_INIT, BYTE_W'(n));
      send_byte(cmd);
      crc = frame_scoreboard_type::crc_step(crc, cmd);
      for (int i = 0; i < n; i++) begin
         b   = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
         crc = frame_scoreboard_type::crc_step(crc, b);
         send_byte(b);
      end
      if (corrupt) crc = crc ^ CRC_W'(1 << $urandom_range(CRC_W - 1));
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
   endtask

   function automatic logic [BYTE_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 60) return BYTE_W'($urandom_range(0, 4));
      if (r < 92) return BYTE_W'($urandom_range(5, 12));
      if (r < 97) return BYTE_W'(PAYLOAD_BYTES);
      return BYTE_W'($urandom_range(PAYLOAD_BYTES + 1, 255));
   endfunction

   task automatic random_traffic(input int count);
      int stop_at;
      int r;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 10) begin
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
         end else if (r < 18) begin
            send_frame(pick_length(), BYTE_W'($urandom), -1, 1'b1);
         end else if (r < 21) begin
            // broken header: wrong second sync byte
            send_byte(cur_first);
            send_byte(~cur_second);
         end else if (r < 24) begin
            // truncated frame: following bytes land in its payload
            send_byte(cur_first);
            send_byte(cur_second);
            send_byte(BYTE_W'($urandom_range(1, 4)));
            send_byte(BYTE_W'($urandom));
         end else begin
            send_frame(pick_length(), BYTE_W'($urandom), -1, 1'b0);
         end
      end
   endtask

   // hold the sender until every result is out and the block has gone quiet
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_preambles(input logic [BYTE_W-1:0] first_v,
                                  input logic [BYTE_W-1:0] second_v);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIRST_PREAMBLE;
      csr_wdata <= first_v;
      @(posedge clock);
      csr_index <= CSR_SECOND_PREAMBLE;
      csr_wdata <= second_v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_preamble(CSR_FIRST_PREAMBLE, first_v);
      sb.set_preamble(CSR_SECOND_PREAMBLE, second_v);
      cur_first  = first_v;
      cur_second = second_v;
   endtask

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_FIRST_PREAMBLE;
      csr_wdata        <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.byte_in <= '0;
      cur_first  = '0;
      cur_second = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset preambles: empty frame and single 0xFF byte
      send_frame(8'd0, 8'h00, 0, 1'b0);
      send_frame(8'd1, 8'hFF, 8'hFF, 1'b0);
      drain();

      write_preambles(8'hA5, 8'h5A);
      // second sync mismatch that equals the first must not restart the hunt
      send_byte(8'hA5);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_frame(8'd1, 8'h80, 8'h00, 1'b0);
      send_frame(8'd0, 8'h42, -1, 1'b1);
      drain();

      // oversized frame behind a long result hold-off; the input backs up
      write_preambles(8'h00, 8'hFF);
      hold_request = 1'b1;
      send_frame(8'd200, BYTE_W'($urandom), -1, 1'b0);
      random_traffic(30);
      drain();

      write_preambles(8'hFF, 8'h00);
      no_idle = 1'b1;
      random_traffic(30);
      drain();
      no_idle = 1'b0;

      write_preambles(BYTE_W'($urandom), BYTE_W'($urandom));
      random_traffic(35);
      drain();

      write_preambles(8'hFF, 8'hFF);
      random_traffic(35);
      drain();

      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule

`default_nettype wire
